/* hw/rtl/sbd_pkg.sv */
// Shared types and constants of the sponge boundary damper.
// Used by every module in hw/rtl; depends on nothing else.

package sbd_pkg;

  // Gain entries are unsigned Q1.16 values.
  localparam int unsigned GAIN_BITS = 17;
  localparam int unsigned FRAC_BITS = 16;

  // Configuration register widths.
  localparam int unsigned LAYER_BITS = 6;
  localparam int unsigned SIZE_BITS  = 13;

  // Load requests carry a fixed 6-bit entry index.
  localparam int unsigned ENTRY_BITS = 6;

  // Configuration port.
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 13;

  localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER_COUNT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERIOR_NX  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERIOR_NY  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INTERIOR_NZ  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FREE_SURFACE = 3'd4;

  // Register values after reset.
  localparam logic [LAYER_BITS-1:0] LAYER_COUNT_RST = 6'd20;
  localparam logic [SIZE_BITS-1:0]  INTERIOR_RST    = 13'd4096;

  // Request operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DAMP = 1'b1;

  // Faces in the order their gains are applied.
  localparam int unsigned NUM_FACES = 6;
  localparam int unsigned FACE_X_LO = 0;
  localparam int unsigned FACE_X_HI = 1;
  localparam int unsigned FACE_Y_LO = 2;
  localparam int unsigned FACE_Y_HI = 3;
  localparam int unsigned FACE_Z_LO = 4;
  localparam int unsigned FACE_Z_HI = 5;

  // Per-sample face selection and the gains read for it.
  typedef struct packed {
    logic [NUM_FACES-1:0]                take;
    logic [NUM_FACES-1:0][GAIN_BITS-1:0] gain;
  } gain_set_t;

  // Low and high layer hits of one axis.
  typedef struct packed {
    logic lo_take;
    logic hi_take;
  } axis_hit_t;

endpackage

/* hw/rtl/sbd_gain_mem.sv */
// Gain table copy: one write port and two registered read ports.
// Depends on sbd_pkg for the gain width.

module sbd_gain_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [AW-1:0]                  waddr_i,
  input  logic [sbd_pkg::GAIN_BITS-1:0]  wdata_i,
  input  logic                           re_i,
  input  logic [AW-1:0]                  raddr0_i,
  input  logic [AW-1:0]                  raddr1_i,
  output logic [sbd_pkg::GAIN_BITS-1:0]  rdata0_o,
  output logic [sbd_pkg::GAIN_BITS-1:0]  rdata1_o
);

  logic [sbd_pkg::GAIN_BITS-1:0] mem_q [DEPTH];
  logic [sbd_pkg::GAIN_BITS-1:0] rdata0_q;
  logic [sbd_pkg::GAIN_BITS-1:0] rdata1_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports; data holds while the consumer is stalled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata0_q <= mem_q[raddr0_i];
      rdata1_q <= mem_q[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* hw/rtl/sbd_depth.sv */
// Layer test and table index for the low and high face of one axis.
// Depends on sbd_pkg for the configuration widths.

module sbd_depth #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned AW          = 6
) (
  input  logic [COORD_BITS-1:0]           coord_i,
  input  logic [sbd_pkg::LAYER_BITS-1:0]  layer_i,
  input  logic [sbd_pkg::SIZE_BITS-1:0]   size_i,
  input  logic                            hi_en_i,
  output sbd_pkg::axis_hit_t              hit_o,
  output logic [AW-1:0]                   lo_idx_o,
  output logic [AW-1:0]                   hi_idx_o
);

  // Signed working width that holds coord + layer - size without overflow.
  localparam int unsigned BW = (COORD_BITS > sbd_pkg::SIZE_BITS) ?
                               COORD_BITS : sbd_pkg::SIZE_BITS;
  localparam int unsigned DW = BW + 2;
  localparam logic signed [DW-1:0] LAST_IDX = DW'(TABLE_DEPTH - 1);

  logic signed [DW-1:0] c_s;
  logic signed [DW-1:0] l_s;
  logic signed [DW-1:0] n_s;
  logic signed [DW-1:0] lo_p;
  logic signed [DW-1:0] hi_p;

  always_comb begin
    c_s = $signed(DW'(coord_i));
    l_s = $signed(DW'(layer_i));
    n_s = $signed(DW'(size_i));
    // Low face: depth L - c, inside the layer when it is not negative.
    lo_p = l_s - c_s;
    // High face: c >= n - L is the same as c + L - n >= 0, which is the depth.
    hi_p = c_s + l_s - n_s;

    hit_o.lo_take = !lo_p[DW-1];
    hit_o.hi_take = hi_en_i && !hi_p[DW-1];

    // Depths past the table use its last entry.
    lo_idx_o = (lo_p > LAST_IDX) ? AW'(TABLE_DEPTH - 1) : lo_p[AW-1:0];
    hi_idx_o = (hi_p > LAST_IDX) ? AW'(TABLE_DEPTH - 1) : hi_p[AW-1:0];
  end

endmodule

/* hw/rtl/sbd_face.sv */
// One face of the damping chain: magnitude multiply, then rounding and
// saturation, as two pipeline stages with valid/ready flow control.
// Depends on sbd_pkg for the gain set type and the fixed-point format.

module sbd_face #(
  parameter int unsigned FACE        = 0,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  sbd_pkg::gain_set_t            set_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output sbd_pkg::gain_set_t            set_o
);

  localparam int unsigned PW = SAMPLE_BITS + sbd_pkg::GAIN_BITS;
  localparam int unsigned RW = PW + 1 - sbd_pkg::FRAC_BITS;
  localparam logic [PW:0]   HALF_LSB = (PW + 1)'(1) << (sbd_pkg::FRAC_BITS - 1);
  localparam logic [RW-1:0] MAX_POS  = {3'b000, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic [RW-1:0] MIN_MAG  = {2'b00, 1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // Stage A: product of magnitude and gain.
  logic                          a_v_q;
  logic                          a_take_q;
  logic                          a_neg_q;
  logic [PW-1:0]                 a_prod_q;
  logic signed [SAMPLE_BITS-1:0] a_sample_q;
  sbd_pkg::gain_set_t            a_set_q;

  // Stage B: rounded, saturated result.
  logic                          b_v_q;
  logic signed [SAMPLE_BITS-1:0] b_sample_q;
  sbd_pkg::gain_set_t            b_set_q;
  logic signed [SAMPLE_BITS-1:0] b_sample_d;

  logic                          a_en;
  logic                          b_en;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [PW-1:0]                 prod;
  logic [PW:0]                   rnd;
  logic [RW-1:0]                 r;

  // A stage takes a new request when empty or when it drains forward.
  assign b_en    = !b_v_q || ready_i;
  assign a_en    = !a_v_q || b_en;
  assign ready_o = a_en;

  // Magnitude of the two's complement sample; the most negative value maps to 2^(N-1).
  always_comb begin
    mag  = sample_i[SAMPLE_BITS-1] ? (~sample_i + 1'b1) : sample_i;
    prod = PW'(mag) * PW'(set_i.gain[FACE]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_en) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_en) begin
      a_take_q   <= set_i.take[FACE];
      a_neg_q    <= sample_i[SAMPLE_BITS-1];
      a_prod_q   <= prod;
      a_sample_q <= sample_i;
      a_set_q    <= set_i;
    end
  end

  // Round to nearest at the fraction point, ties away from zero, then saturate.
  always_comb begin
    rnd = (PW + 1)'(a_prod_q) + HALF_LSB;
    r   = rnd[PW:sbd_pkg::FRAC_BITS];
    if (!a_take_q) begin
      b_sample_d = a_sample_q;
    end else if (a_neg_q) begin
      if (r >= MIN_MAG) begin
        b_sample_d = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
      end else begin
        b_sample_d = ~r[SAMPLE_BITS-1:0] + 1'b1;
      end
    end else begin
      if (r > MAX_POS) begin
        b_sample_d = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
      end else begin
        b_sample_d = r[SAMPLE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (b_en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_en) begin
      b_sample_q <= b_sample_d;
      b_set_q    <= a_set_q;
    end
  end

  assign valid_o  = b_v_q;
  assign sample_o = b_sample_q;
  assign set_o    = b_set_q;

endmodule

/* hw/rtl/sponge_boundary_damper_top.sv */
// Top level of the sponge boundary damper.
// Depends on sbd_pkg, sbd_gain_mem, sbd_depth and sbd_face.

// The damper takes one request per cycle while the output is not stalled
// and returns one damped sample per damp request: the gain table is read
// at the edge that takes the request, then each of the six faces registers
// its multiply and then its rounding and saturation, applied in the order
// x low, x high, y low, y high, z low, z high. Load requests write one
// gain entry and return nothing; a damp request taken in the next cycle
// already sees the new entry. The gain table is kept as three identical
// copies, one per axis, each with two read ports for the low and high face,
// all written by the same load. Table entries have no reset and must be
// loaded before any damp request uses them. Configuration must only be
// written while no request is in flight.

module sponge_boundary_damper_top #(
  parameter int unsigned COORD_BITS  = 12,
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [sbd_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [sbd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  // Request channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic [COORD_BITS-1:0]               pos_x_i,
  input  logic [COORD_BITS-1:0]               pos_y_i,
  input  logic [COORD_BITS-1:0]               pos_z_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic [sbd_pkg::ENTRY_BITS-1:0]      entry_index_i,
  input  logic [sbd_pkg::GAIN_BITS-1:0]       entry_gain_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       damped_sample_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NF = sbd_pkg::NUM_FACES;

  // Configuration registers.
  logic [sbd_pkg::LAYER_BITS-1:0] layer_count_q;
  logic [sbd_pkg::SIZE_BITS-1:0]  interior_nx_q;
  logic [sbd_pkg::SIZE_BITS-1:0]  interior_ny_q;
  logic [sbd_pkg::SIZE_BITS-1:0]  interior_nz_q;
  logic                           free_surface_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layer_count_q  <= sbd_pkg::LAYER_COUNT_RST;
      interior_nx_q  <= sbd_pkg::INTERIOR_RST;
      interior_ny_q  <= sbd_pkg::INTERIOR_RST;
      interior_nz_q  <= sbd_pkg::INTERIOR_RST;
      free_surface_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sbd_pkg::CFG_LAYER_COUNT: begin
          layer_count_q <= cfg_data_i[sbd_pkg::LAYER_BITS-1:0];
        end
        sbd_pkg::CFG_INTERIOR_NX: begin
          interior_nx_q <= cfg_data_i[sbd_pkg::SIZE_BITS-1:0];
        end
        sbd_pkg::CFG_INTERIOR_NY: begin
          interior_ny_q <= cfg_data_i[sbd_pkg::SIZE_BITS-1:0];
        end
        sbd_pkg::CFG_INTERIOR_NZ: begin
          interior_nz_q <= cfg_data_i[sbd_pkg::SIZE_BITS-1:0];
        end
        sbd_pkg::CFG_FREE_SURFACE: begin
          free_surface_q <= cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Face chain handshake nodes: node 0 is the table read stage, node NF the output.
  logic                          node_v   [NF+1];
  logic                          node_rdy [NF+1];
  logic signed [SAMPLE_BITS-1:0] node_s   [NF+1];
  sbd_pkg::gain_set_t            node_set [NF+1];

  // Table read stage.
  logic                          rd_v_q;
  logic [NF-1:0]                 rd_take_q;
  logic signed [SAMPLE_BITS-1:0] rd_sample_q;
  logic                          rd_en;
  logic                          accept;
  logic                          load_we;

  assign rd_en      = !rd_v_q || node_rdy[0];
  assign in_ready_o = rd_en;
  assign accept     = in_valid_i && rd_en;

  // Loads beyond the table are dropped.
  assign load_we = accept && (operation_i == sbd_pkg::OP_LOAD) &&
                   (32'(entry_index_i) < TABLE_DEPTH);

  // Layer tests for the three axes.
  sbd_pkg::axis_hit_t hit_x;
  sbd_pkg::axis_hit_t hit_y;
  sbd_pkg::axis_hit_t hit_z;
  logic [AW-1:0]      x_lo_idx;
  logic [AW-1:0]      x_hi_idx;
  logic [AW-1:0]      y_lo_idx;
  logic [AW-1:0]      y_hi_idx;
  logic [AW-1:0]      z_lo_idx;
  logic [AW-1:0]      z_hi_idx;

  sbd_depth #(
    .COORD_BITS  (COORD_BITS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_depth_x (
    .coord_i  (pos_x_i),
    .layer_i  (layer_count_q),
    .size_i   (interior_nx_q),
    .hi_en_i  (1'b1),
    .hit_o    (hit_x),
    .lo_idx_o (x_lo_idx),
    .hi_idx_o (x_hi_idx)
  );

  sbd_depth #(
    .COORD_BITS  (COORD_BITS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_depth_y (
    .coord_i  (pos_y_i),
    .layer_i  (layer_count_q),
    .size_i   (interior_ny_q),
    .hi_en_i  (1'b1),
    .hit_o    (hit_y),
    .lo_idx_o (y_lo_idx),
    .hi_idx_o (y_hi_idx)
  );

  // The free surface leaves the high z face undamped.
  sbd_depth #(
    .COORD_BITS  (COORD_BITS),
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_depth_z (
    .coord_i  (pos_z_i),
    .layer_i  (layer_count_q),
    .size_i   (interior_nz_q),
    .hi_en_i  (!free_surface_q),
    .hit_o    (hit_z),
    .lo_idx_o (z_lo_idx),
    .hi_idx_o (z_hi_idx)
  );

  // Gain table copies, one per axis.
  logic [sbd_pkg::GAIN_BITS-1:0] gain_rd [NF];
  logic [AW-1:0]                 waddr;

  assign waddr = AW'(entry_index_i);

  sbd_gain_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem_x (
    .clk_i    (clk_i),
    .we_i     (load_we),
    .waddr_i  (waddr),
    .wdata_i  (entry_gain_i),
    .re_i     (rd_en),
    .raddr0_i (x_lo_idx),
    .raddr1_i (x_hi_idx),
    .rdata0_o (gain_rd[sbd_pkg::FACE_X_LO]),
    .rdata1_o (gain_rd[sbd_pkg::FACE_X_HI])
  );

  sbd_gain_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem_y (
    .clk_i    (clk_i),
    .we_i     (load_we),
    .waddr_i  (waddr),
    .wdata_i  (entry_gain_i),
    .re_i     (rd_en),
    .raddr0_i (y_lo_idx),
    .raddr1_i (y_hi_idx),
    .rdata0_o (gain_rd[sbd_pkg::FACE_Y_LO]),
    .rdata1_o (gain_rd[sbd_pkg::FACE_Y_HI])
  );

  sbd_gain_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem_z (
    .clk_i    (clk_i),
    .we_i     (load_we),
    .waddr_i  (waddr),
    .wdata_i  (entry_gain_i),
    .re_i     (rd_en),
    .raddr0_i (z_lo_idx),
    .raddr1_i (z_hi_idx),
    .rdata0_o (gain_rd[sbd_pkg::FACE_Z_LO]),
    .rdata1_o (gain_rd[sbd_pkg::FACE_Z_HI])
  );

  // Read stage registers; only damp requests enter the face chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else if (rd_en) begin
      rd_v_q <= in_valid_i && (operation_i == sbd_pkg::OP_DAMP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_sample_q                   <= sample_i;
      rd_take_q[sbd_pkg::FACE_X_LO] <= hit_x.lo_take;
      rd_take_q[sbd_pkg::FACE_X_HI] <= hit_x.hi_take;
      rd_take_q[sbd_pkg::FACE_Y_LO] <= hit_y.lo_take;
      rd_take_q[sbd_pkg::FACE_Y_HI] <= hit_y.hi_take;
      rd_take_q[sbd_pkg::FACE_Z_LO] <= hit_z.lo_take;
      rd_take_q[sbd_pkg::FACE_Z_HI] <= hit_z.hi_take;
    end
  end

  // Gather selections and gains into the set that rides down the chain.
  always_comb begin
    node_set[0].take = rd_take_q;
    for (int f = 0; f < NF; f++) begin
      node_set[0].gain[f] = gain_rd[f];
    end
  end

  assign node_v[0] = rd_v_q;
  assign node_s[0] = rd_sample_q;

  // Six face stages in application order.
  for (genvar f = 0; f < NF; f++) begin : g_face
    sbd_face #(
      .FACE        (f),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_face (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (node_v[f]),
      .ready_o  (node_rdy[f]),
      .sample_i (node_s[f]),
      .set_i    (node_set[f]),
      .valid_o  (node_v[f+1]),
      .ready_i  (node_rdy[f+1]),
      .sample_o (node_s[f+1]),
      .set_o    (node_set[f+1])
    );
  end

  // The last face stage is the output register.
  assign node_rdy[NF]    = out_ready_i;
  assign out_valid_o     = node_v[NF];
  assign damped_sample_o = node_s[NF];

  // The final gain set has no consumer past the chain.
  sbd_pkg::gain_set_t unused_set;
  assign unused_set = node_set[NF];

endmodule
